>>> rtl/gddc_pkg.sv
package gddc_pkg;

  // field widths
  localparam int unsigned DAY_W          = 5;
  localparam int unsigned MONTH_W        = 4;
  localparam int unsigned YEAR_W         = 14;
  // walked year carries one extra bit so a wrap past the top still compares as later
  localparam int unsigned WYEAR_W        = YEAR_W + 1;
  localparam int unsigned COUNT_OUT_W    = 22;
  localparam int unsigned COUNT_BITS_DEF = 22;
  localparam int unsigned LEN_W          = 9;

  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
  localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
  localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
  localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

  localparam logic [DAY_W-1:0] DAY_FIRST = 5'd1;
  localparam logic [DAY_W-1:0] LEN_FEB   = 5'd28;
  localparam logic [DAY_W-1:0] LEN_FEB_L = 5'd29;
  localparam logic [DAY_W-1:0] LEN_SHORT = 5'd30;
  localparam logic [DAY_W-1:0] LEN_LONG  = 5'd31;

  localparam logic [LEN_W-1:0] YEAR_LEN      = 9'd365;
  localparam logic [LEN_W-1:0] LEAP_YEAR_LEN = 9'd366;

  // inverse of 25 modulo 2^15 and the largest product of a multiple of 25
  localparam logic [WYEAR_W-1:0] INV25       = 15'd23593;
  localparam logic [WYEAR_W-1:0] DIV25_LIMIT = 15'd1310;

  typedef struct packed {
    logic load;
    logic advance;
    logic capture;
  } gddc_cmd_t;

  typedef struct packed {
    logic finish;
  } gddc_sts_t;

  // 4/100/400 rule: 4 | y and (25 does not divide y, or 16 | y)
  function automatic logic is_leap(input logic [WYEAR_W-1:0] y);
    logic [WYEAR_W-1:0] prod;
    logic               div25;
    prod  = WYEAR_W'(y * INV25);
    div25 = (prod <= DIV25_LIMIT);
    return (y[1:0] == 2'd0) && (!div25 || (y[3:0] == 4'd0));
  endfunction

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
    logic [DAY_W-1:0] len;
    len = LEN_LONG;
    if (m inside {MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV}) begin
      len = LEN_SHORT;
    end else if (m == MONTH_FEB) begin
      len = leap ? LEN_FEB_L : LEN_FEB;
    end
    return len;
  endfunction

endpackage

>>> rtl/gregorian_day_difference_counter.sv
// channel   direction  handshake                fields
// in        request    in_valid_i / in_stall_o   start_day/month/year, end_day/month/year
// out       result     out_valid_o / out_stall_i day_count, range_error
//
// one walk step per cycle: a day, or a whole year when the walk sits on new year's day before the end year
// and the count has room for it; request to result: a load, the walk steps, then the capture of the final compare,
// the walk stepping over the days of the partial years and taking each whole year spanned as one step
// asynchronous active-low reset clears the controller and the result valid only
// a result held under out_stall_i does not block the next request, only the next result
module gregorian_day_difference_counter #(
  parameter int unsigned COUNT_BITS = gddc_pkg::COUNT_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // request channel
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [gddc_pkg::DAY_W-1:0]       start_day_i,
  input  logic [gddc_pkg::MONTH_W-1:0]     start_month_i,
  input  logic [gddc_pkg::YEAR_W-1:0]      start_year_i,
  input  logic [gddc_pkg::DAY_W-1:0]       end_day_i,
  input  logic [gddc_pkg::MONTH_W-1:0]     end_month_i,
  input  logic [gddc_pkg::YEAR_W-1:0]      end_year_i,
  // result channel
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [gddc_pkg::COUNT_OUT_W-1:0] day_count_o,
  output logic                             range_error_o
);
  import gddc_pkg::*;

  // commands from the controller, finish status back from the datapath
  gddc_cmd_t cmd;
  gddc_sts_t sts;

  // controller: idle / walk sequencing and the result valid flag
  gddc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // datapath: walked date, day counter, end date and result register
  gddc_dp #(
    .CountBits (COUNT_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .start_day_i   (start_day_i),
    .start_month_i (start_month_i),
    .start_year_i  (start_year_i),
    .end_day_i     (end_day_i),
    .end_month_i   (end_month_i),
    .end_year_i    (end_year_i),
    .day_count_o   (day_count_o),
    .range_error_o (range_error_o)
  );

endmodule

>>> rtl/gddc_dp.sv
module gddc_dp #(
  parameter int unsigned CountBits = gddc_pkg::COUNT_BITS_DEF
) (
  input  logic                                 clk_i,
  input  gddc_pkg::gddc_cmd_t                  cmd_i,
  output gddc_pkg::gddc_sts_t                  sts_o,
  input  logic [gddc_pkg::DAY_W-1:0]           start_day_i,
  input  logic [gddc_pkg::MONTH_W-1:0]         start_month_i,
  input  logic [gddc_pkg::YEAR_W-1:0]          start_year_i,
  input  logic [gddc_pkg::DAY_W-1:0]           end_day_i,
  input  logic [gddc_pkg::MONTH_W-1:0]         end_month_i,
  input  logic [gddc_pkg::YEAR_W-1:0]          end_year_i,
  output logic [gddc_pkg::COUNT_OUT_W-1:0]     day_count_o,
  output logic                                 range_error_o
);
  import gddc_pkg::*;

  localparam logic [CountBits-1:0] CountMax = '1;

  logic [DAY_W-1:0]       day_q, day_d;
  logic [MONTH_W-1:0]     month_q, month_d;
  logic [WYEAR_W-1:0]     year_q, year_d;
  logic [DAY_W-1:0]       end_day_q, end_day_d;
  logic [MONTH_W-1:0]     end_month_q, end_month_d;
  logic [YEAR_W-1:0]      end_year_q, end_year_d;
  logic [CountBits-1:0]   count_q, count_d;
  logic [COUNT_OUT_W-1:0] day_count_q, day_count_d;
  logic                   range_error_q, range_error_d;

  logic                   leap;
  logic [DAY_W-1:0]       mlen;
  logic [LEN_W-1:0]       year_len;
  logic [WYEAR_W-1:0]     end_year_ext;
  logic                   match;
  logic                   overrun;
  logic                   shortcut;
  logic [DAY_W:0]         day_inc;
  logic [MONTH_W:0]       month_inc;

  assign leap         = is_leap(year_q);
  assign mlen         = month_len(month_q, leap);
  assign year_len     = leap ? LEAP_YEAR_LEN : YEAR_LEN;
  assign end_year_ext = {1'b0, end_year_q};
  assign match        = (day_q == end_day_q) && (month_q == end_month_q)
                        && (year_q == end_year_ext);
  assign overrun      = (year_q > end_year_ext) || (count_q == CountMax);
  // whole year from new year's day, before the end year, when the count has room for it
  assign shortcut     = (day_q == DAY_FIRST) && (month_q == MONTH_JAN)
                        && (year_q < end_year_ext)
                        && (~count_q >= CountBits'(year_len));
  assign day_inc      = {1'b0, day_q} + 1'b1;
  assign month_inc    = {1'b0, month_q} + 1'b1;

  assign sts_o.finish = match || overrun;

  always_comb begin
    day_d         = day_q;
    month_d       = month_q;
    year_d        = year_q;
    end_day_d     = end_day_q;
    end_month_d   = end_month_q;
    end_year_d    = end_year_q;
    count_d       = count_q;
    day_count_d   = day_count_q;
    range_error_d = range_error_q;
    if (cmd_i.load) begin
      day_d       = start_day_i;
      month_d     = start_month_i;
      year_d      = {1'b0, start_year_i};
      end_day_d   = end_day_i;
      end_month_d = end_month_i;
      end_year_d  = end_year_i;
      count_d     = '0;
    end else if (cmd_i.advance) begin
      if (shortcut) begin
        count_d = count_q + CountBits'(year_len);
        year_d  = year_q + 1'b1;
      end else begin
        count_d = count_q + 1'b1;
        if (day_inc > {1'b0, mlen}) begin
          day_d = DAY_FIRST;
          if (month_inc > {1'b0, MONTH_DEC}) begin
            month_d = MONTH_JAN;
            year_d  = year_q + 1'b1;
          end else begin
            month_d = month_inc[MONTH_W-1:0];
          end
        end else begin
          day_d = day_inc[DAY_W-1:0];
        end
      end
    end
    if (cmd_i.capture) begin
      day_count_d   = COUNT_OUT_W'(count_q);
      range_error_d = !match;
    end
  end

  always_ff @(posedge clk_i) begin
    day_q         <= day_d;
    month_q       <= month_d;
    year_q        <= year_d;
    end_day_q     <= end_day_d;
    end_month_q   <= end_month_d;
    end_year_q    <= end_year_d;
    count_q       <= count_d;
    day_count_q   <= day_count_d;
    range_error_q <= range_error_d;
  end

  assign day_count_o   = day_count_q;
  assign range_error_o = range_error_q;

endmodule

>>> rtl/gddc_ctrl.sv
module gddc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output gddc_pkg::gddc_cmd_t cmd_o,
  input  gddc_pkg::gddc_sts_t sts_i
);
  import gddc_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_WALK = 2'b10
  } gddc_state_e;

  gddc_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    in_stall_o    = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_WALK;
        end
      end
      ST_WALK: begin
        if (sts_i.finish) begin
          // hold the walk until the result register is free
          if (out_free) begin
            cmd_o.capture = 1'b1;
            state_d       = ST_IDLE;
          end
        end else begin
          cmd_o.advance = 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_d = cmd_o.capture || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

>>> rtl/gddc_chk.sv
module gddc_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic [4:0]  start_day_i,
  input logic [3:0]  start_month_i,
  input logic [13:0] start_year_i,
  input logic [4:0]  end_day_i,
  input logic [3:0]  end_month_i,
  input logic [13:0] end_year_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [21:0] day_count_o,
  input logic        range_error_o
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(day_count_o)
                                   && $stable(range_error_o))
    else $error("stalled result changed");

  // an accepted request starts a walk
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request accepted while walking");

  // a new result only appears as the walk ends
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $fell(in_stall_o))
    else $error("result without end of walk");

  // no result in the cycle right after a request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> !$rose(out_valid_o))
    else $error("result too early");

endmodule

bind gregorian_day_difference_counter gddc_chk u_gddc_chk (.*);
